>>> src/shc_pkg.sv
// Shared types, widths and register codes for the sweep hit classifier.
// Used by shc_alu, shc_core and sweep_hit_classifier; depends on nothing.
package shc_pkg;

  localparam int SENSORS   = 32;
  localparam int HIT_SLOTS = 4;
  localparam int HIT_IN    = 4;
  localparam int TS_W      = 32;
  localparam int ALU_W     = TS_W + 1;
  localparam int ANG_W     = 16;
  localparam int PC_W      = 6;
  localparam int SLOT_W    = 2;
  localparam int BIT_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [TS_W-1:0] PERIOD_MIN_RST      = 32'd800000;
  localparam logic [TS_W-1:0] PERIOD_MAX_RST      = 32'd970000;
  localparam logic [TS_W-1:0] FALLBACK_PERIOD_RST = 32'd900000;
  localparam logic [ANG_W-1:0] ANG_SAT            = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_MIN      = 2'd0,
    CFG_PERIOD_MAX      = 2'd1,
    CFG_FALLBACK_PERIOD = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_NEG,
    S_LMIN,
    S_LMAX,
    S_DIST,
    S_CLASS,
    S_DECIDE,
    S_DPRE,
    S_DSTEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TS_W-1:0] period_min;
    logic [TS_W-1:0] period_max;
    logic [TS_W-1:0] fallback_period;
  } cfg_t;

  typedef struct packed {
    logic [3:0]                  channel;
    logic [4:0]                  sensor;
    logic [TS_W-1:0]             last_sync;
    logic [TS_W-1:0]             current_sync;
    logic [HIT_IN-1:0][TS_W-1:0] hit_time;
    logic [3:0]                  sweep_count;
    logic                        channel_ready;
    logic                        frame_end;
  } rec_t;

  typedef struct packed {
    logic [3:0]       out_channel;
    logic [4:0]       out_sensor;
    logic             rejected;
    logic             pair_valid;
    logic [TS_W-1:0]  timecode_a;
    logic [TS_W-1:0]  timecode_b;
    logic [ANG_W-1:0] angle_a;
    logic [ANG_W-1:0] angle_b;
    logic [PC_W-1:0]  valid_pairs;
    logic             out_frame_end;
  } res_t;

endpackage

>>> src/shc_alu.sv
// Shared subtract/compare unit of the classifier datapath.
// Depends on shc_pkg for the operand width.
module shc_alu (
  input  logic [shc_pkg::ALU_W-1:0] a,
  input  logic [shc_pkg::ALU_W-1:0] b,
  output logic [shc_pkg::ALU_W-1:0] diff,
  output logic                      borrow
);

  logic [shc_pkg::ALU_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[shc_pkg::ALU_W-1:0];
  assign borrow = full[shc_pkg::ALU_W];

endmodule

>>> src/shc_core.sv
// Sequencer and datapath registers: period pick, hit classing, serial angle division.
// Depends on shc_pkg and shc_alu.
module shc_core (
  input  logic          clk,
  input  logic          rst,
  input  shc_pkg::cfg_t cfg,
  input  shc_pkg::rec_t rec,
  input  logic          rec_valid,
  output logic          rec_ready,
  output shc_pkg::res_t res,
  output logic          res_valid,
  input  logic          res_take
);

  localparam logic [shc_pkg::SLOT_W-1:0] SLOT_LAST = shc_pkg::SLOT_W'(shc_pkg::HIT_SLOTS - 1);
  localparam logic [shc_pkg::BIT_W-1:0]  BIT_LAST  = shc_pkg::BIT_W'(shc_pkg::ANG_W - 1);
  localparam logic [shc_pkg::PC_W-1:0]   PC_MAX    = shc_pkg::PC_W'(shc_pkg::SENSORS);

  shc_pkg::state_t state, state_next;

  logic [3:0]                  channel;
  logic [4:0]                  sensor;
  logic [shc_pkg::TS_W-1:0]    last_sync;
  logic [shc_pkg::TS_W-1:0]    current_sync;
  logic [shc_pkg::TS_W-1:0]    hit [shc_pkg::HIT_SLOTS];
  logic [shc_pkg::TS_W-1:0]    hit_dist [shc_pkg::HIT_SLOTS];
  logic [shc_pkg::HIT_SLOTS-1:0] fresh;
  logic [3:0]                  sweeps;
  logic                        fend;
  logic [shc_pkg::TS_W-1:0]    tmp;
  logic                        tmp_borrow;
  logic [shc_pkg::TS_W-1:0]    meas;
  logic                        gt_min;
  logic [shc_pkg::TS_W-1:0]    period;
  logic                        per_zero;
  logic                        seen0, seen1, dup0, dup1;
  logic                        rej, pv;
  logic [shc_pkg::PC_W-1:0]    pair_count;
  logic [shc_pkg::PC_W-1:0]    vp;
  logic [shc_pkg::SLOT_W-1:0]  slot;
  logic [shc_pkg::BIT_W-1:0]   bit_cnt;
  logic [shc_pkg::TS_W-1:0]    rem;
  logic [shc_pkg::ANG_W-1:0]   quo;
  logic [shc_pkg::ANG_W-1:0]   ang_a, ang_b;

  logic [shc_pkg::ALU_W-1:0]   alu_a, alu_b, alu_diff;
  logic                        alu_borrow;
  logic                        rec_live;
  logic [shc_pkg::TS_W-1:0]    abs_d;
  logic                        rej_c, pv_c;
  logic [shc_pkg::PC_W-1:0]    pc_new;
  logic                        qbit;
  logic [shc_pkg::ANG_W-1:0]   quo_next;

  shc_alu u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .diff   (alu_diff),
    .borrow (alu_borrow)
  );

  assign rec_live = rec.channel_ready && (rec.last_sync != '0);
  assign abs_d    = tmp_borrow ? alu_diff[shc_pkg::TS_W-1:0] : tmp;
  assign rej_c    = dup0 || dup1 || (sweeps > 4'd2);
  assign pv_c     = !rej_c && (sweeps == 4'd2);
  assign pc_new   = (pv_c && (pair_count < PC_MAX)) ? pair_count + 1'b1 : pair_count;
  assign qbit     = !alu_borrow;
  assign quo_next = {quo[shc_pkg::ANG_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rec_ready  = 1'b0;
    res_valid  = 1'b0;
    alu_a      = '0;
    alu_b      = '0;
    case (state)
      shc_pkg::S_IDLE: begin
        rec_ready = !rst;
        if (rec_valid && rec_live) begin
          state_next = shc_pkg::S_DIFF;
        end
      end
      shc_pkg::S_DIFF: begin
        alu_a      = {1'b0, current_sync};
        alu_b      = {1'b0, last_sync};
        state_next = shc_pkg::S_NEG;
      end
      shc_pkg::S_NEG: begin
        alu_a      = {1'b0, last_sync};
        alu_b      = {1'b0, current_sync};
        state_next = shc_pkg::S_LMIN;
      end
      shc_pkg::S_LMIN: begin
        alu_a      = {1'b0, cfg.period_min};
        alu_b      = {1'b0, meas};
        state_next = shc_pkg::S_LMAX;
      end
      shc_pkg::S_LMAX: begin
        alu_a      = {1'b0, meas};
        alu_b      = {1'b0, cfg.period_max};
        state_next = shc_pkg::S_DIST;
      end
      shc_pkg::S_DIST: begin
        alu_a = {1'b0, hit[slot]};
        alu_b = {1'b0, last_sync};
        if (slot == SLOT_LAST) begin
          state_next = shc_pkg::S_CLASS;
        end
      end
      shc_pkg::S_CLASS: begin
        alu_a = {1'b0, hit_dist[slot]};
        alu_b = {2'b00, period[shc_pkg::TS_W-1:1]};
        if (slot == SLOT_LAST) begin
          state_next = shc_pkg::S_DECIDE;
        end
      end
      shc_pkg::S_DECIDE: begin
        state_next = pv_c ? shc_pkg::S_DPRE : shc_pkg::S_DONE;
      end
      shc_pkg::S_DPRE: begin
        alu_a = {1'b0, hit_dist[slot]};
        alu_b = {1'b0, period};
        if (per_zero || !alu_borrow) begin
          state_next = slot[0] ? shc_pkg::S_DONE : shc_pkg::S_DPRE;
        end else begin
          state_next = shc_pkg::S_DSTEP;
        end
      end
      shc_pkg::S_DSTEP: begin
        alu_a = {rem, 1'b0};
        alu_b = {1'b0, period};
        if (bit_cnt == BIT_LAST) begin
          state_next = slot[0] ? shc_pkg::S_DONE : shc_pkg::S_DPRE;
        end
      end
      shc_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = shc_pkg::S_IDLE;
        end
      end
      default: state_next = shc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= '0;
    end else if (state == shc_pkg::S_IDLE && rec_valid && !rec_live && rec.frame_end) begin
      pair_count <= '0;
    end else if (state == shc_pkg::S_DECIDE) begin
      pair_count <= fend ? '0 : pc_new;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      shc_pkg::S_IDLE: begin
        channel      <= rec.channel;
        sensor       <= rec.sensor;
        last_sync    <= rec.last_sync;
        current_sync <= rec.current_sync;
        sweeps       <= rec.sweep_count;
        fend         <= rec.frame_end;
        for (int i = 0; i < shc_pkg::HIT_SLOTS; i++) begin
          hit[i] <= rec.hit_time[i];
        end
        slot  <= '0;
        seen0 <= 1'b0;
        seen1 <= 1'b0;
        dup0  <= 1'b0;
        dup1  <= 1'b0;
      end
      shc_pkg::S_DIFF: begin
        tmp        <= alu_diff[shc_pkg::TS_W-1:0];
        tmp_borrow <= alu_borrow;
      end
      shc_pkg::S_NEG: begin
        meas <= abs_d[shc_pkg::TS_W-1] ? ~abs_d : abs_d;
      end
      shc_pkg::S_LMIN: begin
        gt_min <= alu_borrow;
      end
      shc_pkg::S_LMAX: begin
        if (gt_min && alu_borrow) begin
          period   <= meas;
          per_zero <= (meas == '0);
        end else begin
          period   <= cfg.fallback_period;
          per_zero <= (cfg.fallback_period == '0);
        end
      end
      shc_pkg::S_DIST: begin
        fresh[slot]    <= !alu_borrow && (alu_diff[shc_pkg::TS_W-1:0] != '0);
        hit_dist[slot] <= alu_borrow ? '0 : alu_diff[shc_pkg::TS_W-1:0];
        slot           <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      end
      shc_pkg::S_CLASS: begin
        if (fresh[slot]) begin
          if (alu_borrow) begin
            seen0 <= 1'b1;
            dup0  <= dup0 || seen0;
          end else begin
            seen1 <= 1'b1;
            dup1  <= dup1 || seen1;
          end
        end
        slot <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
      end
      shc_pkg::S_DECIDE: begin
        rej  <= rej_c;
        pv   <= pv_c;
        vp   <= pc_new;
        slot <= '0;
      end
      shc_pkg::S_DPRE: begin
        rem     <= hit_dist[slot][shc_pkg::TS_W-1:0];
        quo     <= '0;
        bit_cnt <= '0;
        if (per_zero || !alu_borrow) begin
          if (slot[0]) begin
            ang_b <= (per_zero && hit_dist[slot] == '0) ? '0 : shc_pkg::ANG_SAT;
          end else begin
            ang_a <= (per_zero && hit_dist[slot] == '0) ? '0 : shc_pkg::ANG_SAT;
          end
          slot <= slot + 1'b1;
        end
      end
      shc_pkg::S_DSTEP: begin
        rem     <= qbit ? alu_diff[shc_pkg::TS_W-1:0] : alu_a[shc_pkg::TS_W-1:0];
        quo     <= quo_next;
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_LAST) begin
          if (slot[0]) begin
            ang_b <= quo_next;
          end else begin
            ang_a <= quo_next;
          end
          slot <= slot + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.out_channel   = channel;
    res.out_sensor    = sensor;
    res.rejected      = rej;
    res.pair_valid    = pv;
    res.timecode_a    = (rej || !fresh[0]) ? '0 : hit[0];
    res.timecode_b    = (rej || !fresh[1]) ? '0 : hit[1];
    res.angle_a       = pv ? ang_a : '0;
    res.angle_b       = pv ? ang_b : '0;
    res.valid_pairs   = vp;
    res.out_frame_end = fend;
  end

  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    pair_count <= PC_MAX)
    else $error("pair count above sensor count");

  a_pv_not_rej: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.pair_valid && res.rejected))
    else $error("pair valid on a rejected record");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == shc_pkg::S_DSTEP |-> rem < period)
    else $error("division remainder not below period");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == shc_pkg::S_IDLE && rec_valid && !rec_live && rec.frame_end
      |=> pair_count == '0)
    else $error("frame end of an idle record did not clear count");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("result changed before it was taken");

endmodule

>>> src/sweep_hit_classifier.sv
// Top level of the sweep hit classifier: stream ports, config registers, output register.
// Depends on shc_pkg and shc_core.
//
//  channel   | dir | tdata                               | tuser                  | tlast
//  s_*       | in  | record fields, 208 bits             | channel_ready          | frame_end
//  m_*       | out | result fields, 112 bits             | rejected, pair_valid   | out_frame_end
//  cfg_*     | in  | period_min, period_max, fallback    | -                      | -
//
// A record with a valid pair also runs the serial angle division:
// the two 16-bit angles come from one shared 33-bit subtractor, one quotient bit a cycle.
// s_tready is high only while the sequencer is idle; a record with channel_ready low
// or last_sync zero is accepted without leaving idle and gives no word.
// The output register lets the next record start while a result word waits on m_tready.
// rst is synchronous and restores the register defaults and clears the pair count.
module sweep_hit_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // channel, sensor, last_sync, current_sync, hit_time_0..3, sweep_count, zero pad
  input  logic [207:0] s_tdata,
  // channel_ready
  input  logic         s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_channel, out_sensor, timecode_a, timecode_b, angle_a, angle_b, valid_pairs, zero pad
  output logic [111:0] m_tdata,
  // rejected, pair_valid
  output logic [1:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_we,
  input  logic [shc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [shc_pkg::TS_W-1:0]      cfg_wdata
);

  shc_pkg::cfg_t cfg;
  shc_pkg::rec_t rec;
  shc_pkg::res_t res;
  shc_pkg::res_t out_res;
  logic          res_valid;
  logic          res_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_min      <= shc_pkg::PERIOD_MIN_RST;
      cfg.period_max      <= shc_pkg::PERIOD_MAX_RST;
      cfg.fallback_period <= shc_pkg::FALLBACK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        shc_pkg::CFG_PERIOD_MIN:      cfg.period_min      <= cfg_wdata;
        shc_pkg::CFG_PERIOD_MAX:      cfg.period_max      <= cfg_wdata;
        shc_pkg::CFG_FALLBACK_PERIOD: cfg.fallback_period <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rec.channel       = s_tdata[3:0];
    rec.sensor        = s_tdata[8:4];
    rec.last_sync     = s_tdata[40:9];
    rec.current_sync  = s_tdata[72:41];
    rec.hit_time[0]   = s_tdata[104:73];
    rec.hit_time[1]   = s_tdata[136:105];
    rec.hit_time[2]   = s_tdata[168:137];
    rec.hit_time[3]   = s_tdata[200:169];
    rec.sweep_count   = s_tdata[204:201];
    rec.channel_ready = s_tuser;
    rec.frame_end     = s_tlast;
  end

  shc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec       (rec),
    .rec_valid (s_tvalid),
    .rec_ready (s_tready),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign m_tdata = {1'b0, out_res.valid_pairs, out_res.angle_b, out_res.angle_a,
                    out_res.timecode_b, out_res.timecode_a, out_res.out_sensor,
                    out_res.out_channel};
  assign m_tuser = {out_res.pair_valid, out_res.rejected};
  assign m_tlast = out_res.out_frame_end;

endmodule

>>> tb/sv/sweep_hit_classifier_tb.sv
// Self-checking bench for sweep_hit_classifier: directed and random sensor records,
// predicted with a local model of period, plane and angle logic. Depends on shc_pkg.
module sweep_hit_classifier_tb;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [207:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we = 1'b0;
  shc_pkg::cfg_idx_t cfg_index = shc_pkg::CFG_PERIOD_MIN;
  logic [31:0]  cfg_wdata = '0;

  sweep_hit_classifier dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  shc_pkg::rec_t records_to_send[$];
  shc_pkg::res_t hit_reports_due[$];
  shc_pkg::rec_t rec_on_bus;
  logic [31:0] lim_min = shc_pkg::PERIOD_MIN_RST;
  logic [31:0] lim_max = shc_pkg::PERIOD_MAX_RST;
  logic [31:0] fallback = shc_pkg::FALLBACK_PERIOD_RST;
  logic [5:0]  pairs_in_frame = '0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          fails = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] turn_share(logic [31:0] d, logic [31:0] per);
    logic [63:0] q;
    if (per == 0) return (d != 0) ? 16'hFFFF : 16'h0000;
    q = {16'h0000, d, 16'h0000} / {32'h0, per};
    return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic bit classify_record(input shc_pkg::rec_t r, output shc_pkg::res_t res);
    logic [31:0] diff, per, half;
    logic [31:0] hit [4];
    logic [31:0] hit_dist [4];
    int n0, n1;
    bit rej, pv;
    res = '0;
    n0 = 0;
    n1 = 0;
    if (!r.channel_ready || r.last_sync == 0) begin
      if (r.frame_end) pairs_in_frame = '0;
      return 1'b0;
    end
    diff = (r.current_sync > r.last_sync) ? r.current_sync - r.last_sync
                                          : r.last_sync - r.current_sync;
    per = (diff > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF - diff : diff;
    if (!(per > lim_min && per < lim_max)) per = fallback;
    half = per >> 1;
    for (int i = 0; i < 4; i++) begin
      hit[i] = r.hit_time[i];
      hit_dist[i] = '0;
      if (hit[i] > r.last_sync) hit_dist[i] = hit[i] - r.last_sync;
      else hit[i] = '0;
      if (i < shc_pkg::HIT_SLOTS && hit[i] != 0) begin
        if (hit_dist[i] < half) n0++;
        else n1++;
      end
    end
    rej = (n0 > 1) || (n1 > 1) || (r.sweep_count > 2);
    pv = !rej && r.sweep_count == 2;
    if (pv && pairs_in_frame < shc_pkg::SENSORS) pairs_in_frame++;
    res.out_channel   = r.channel;
    res.out_sensor    = r.sensor;
    res.rejected      = rej;
    res.pair_valid    = pv;
    res.timecode_a    = rej ? '0 : hit[0];
    res.timecode_b    = rej ? '0 : hit[1];
    res.angle_a       = pv ? turn_share(hit_dist[0], per) : '0;
    res.angle_b       = pv ? turn_share(hit_dist[1], per) : '0;
    res.valid_pairs   = pairs_in_frame;
    res.out_frame_end = r.frame_end;
    if (r.frame_end) pairs_in_frame = '0;
    return 1'b1;
  endfunction

  function automatic shc_pkg::rec_t gen_record(int fend_pct);
    shc_pkg::rec_t r;
    int kind;
    logic [31:0] per, half, tmp;
    kind = $urandom_range(99);
    r.channel = 4'($urandom);
    r.sensor = 5'($urandom);
    if (kind >= 85) begin
      r.last_sync = $urandom;
      r.current_sync = $urandom;
      for (int i = 0; i < 4; i++) r.hit_time[i] = $urandom;
      r.sweep_count = 4'($urandom);
      r.channel_ready = $urandom_range(3) != 0;
    end else begin
      r.channel_ready = 1'b1;
      r.last_sync = $urandom_range(32'hFFE0_0000, 1);
      per = $urandom_range(990000, 780000);
      half = per >> 1;
      case ($urandom_range(9))
        0: r.current_sync = (r.last_sync > per) ? r.last_sync - per : r.last_sync + per;
        1: r.current_sync = $urandom;
        default: r.current_sync = r.last_sync + per;
      endcase
      r.hit_time[0] = r.last_sync + $urandom_range(half - 1, 1);
      r.hit_time[1] = r.last_sync + (($urandom_range(4) == 0) ? $urandom_range(2 * per, half)
                                                              : $urandom_range(per - 1, half));
      r.hit_time[2] = $urandom_range(r.last_sync, 0);
      r.hit_time[3] = $urandom_range(r.last_sync, 0);
      if ($urandom_range(3) == 0) begin
        tmp = r.hit_time[0];
        r.hit_time[0] = r.hit_time[1];
        r.hit_time[1] = tmp;
      end
      if ($urandom_range(5) == 0) begin
        tmp = r.hit_time[0];
        r.hit_time[0] = r.hit_time[2];
        r.hit_time[2] = tmp;
      end
      r.sweep_count = ($urandom_range(4) != 0) ? 4'd2 : 4'($urandom_range(2));
      if (kind >= 75) begin
        case ($urandom_range(2))
          0: r.sweep_count = 4'($urandom_range(15, 3));
          1: r.hit_time[2] = r.last_sync + $urandom_range(half - 1, 1);
          default: r.hit_time[3] = r.last_sync + $urandom_range(per - 1, half);
        endcase
      end
    end
    r.frame_end = $urandom_range(99) < fend_pct;
    return r;
  endfunction

  task automatic queue_batch(int n, int fend_pct);
    repeat (n) records_to_send.push_back(gen_record(fend_pct));
  endtask

  task automatic drain();
    @(negedge clk);
    while (records_to_send.size() != 0 || s_tvalid || hit_reports_due.size() != 0)
      @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_register(shc_pkg::cfg_idx_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      shc_pkg::CFG_PERIOD_MIN: lim_min = v;
      shc_pkg::CFG_PERIOD_MAX: lim_max = v;
      shc_pkg::CFG_FALLBACK_PERIOD: fallback = v;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [31:0] mn, logic [31:0] mx, logic [31:0] fb);
    set_register(shc_pkg::CFG_PERIOD_MIN, mn);
    set_register(shc_pkg::CFG_PERIOD_MAX, mx);
    set_register(shc_pkg::CFG_FALLBACK_PERIOD, fb);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // advance a word when the block takes it, hold it otherwise
  always @(posedge clk) begin
    shc_pkg::res_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid && classify_record(rec_on_bus, res)) hit_reports_due.push_back(res);
      if (records_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        rec_on_bus = records_to_send.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, rec_on_bus.sweep_count, rec_on_bus.hit_time[3],
                    rec_on_bus.hit_time[2], rec_on_bus.hit_time[1], rec_on_bus.hit_time[0],
                    rec_on_bus.current_sync, rec_on_bus.last_sync,
                    rec_on_bus.sensor, rec_on_bus.channel};
        s_tuser <= rec_on_bus.channel_ready;
        s_tlast <= rec_on_bus.frame_end;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    shc_pkg::res_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (hit_reports_due.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          want = hit_reports_due.pop_front();
          check_field("out_channel", 32'(want.out_channel), 32'(m_tdata[3:0]));
          check_field("out_sensor", 32'(want.out_sensor), 32'(m_tdata[8:4]));
          check_field("rejected", 32'(want.rejected), 32'(m_tuser[0]));
          check_field("pair_valid", 32'(want.pair_valid), 32'(m_tuser[1]));
          check_field("timecode_a", want.timecode_a, m_tdata[40:9]);
          check_field("timecode_b", want.timecode_b, m_tdata[72:41]);
          check_field("angle_a", 32'(want.angle_a), 32'(m_tdata[88:73]));
          check_field("angle_b", 32'(want.angle_b), 32'(m_tdata[104:89]));
          check_field("valid_pairs", 32'(want.valid_pairs), 32'(m_tdata[110:105]));
          check_field("out_frame_end", 32'(want.out_frame_end), 32'(m_tlast));
        end
      end
      m_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  initial begin
    shc_pkg::rec_t base;
    shc_pkg::rec_t r;
    base.channel = 4'd3;
    base.sensor = 5'd7;
    base.last_sync = 32'd1_000_000;
    base.current_sync = 32'd1_900_000;
    base.hit_time[0] = 32'd1_100_000;
    base.hit_time[1] = 32'd1_600_000;
    base.hit_time[2] = '0;
    base.hit_time[3] = '0;
    base.sweep_count = 4'd2;
    base.channel_ready = 1'b1;
    base.frame_end = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    records_to_send.push_back(base);
    r = base; r.channel = 4'hF; r.sensor = 5'h1F; records_to_send.push_back(r);
    r = base; r.channel_ready = 1'b0; records_to_send.push_back(r);
    r = base; r.last_sync = '0; records_to_send.push_back(r);
    r = base; r.sweep_count = 4'd3; records_to_send.push_back(r);
    r = base; r.hit_time[2] = 32'd1_200_000; records_to_send.push_back(r);
    r = base; r.hit_time[3] = 32'd1_700_000; records_to_send.push_back(r);
    r = base; r.sweep_count = 4'd1; records_to_send.push_back(r);
    r = base; r.sweep_count = 4'd0; r.channel = '0; r.sensor = '0; records_to_send.push_back(r);
    r = base; r.hit_time[0] = 32'd1_000_000; r.hit_time[1] = 32'd5;
    r.hit_time[2] = 32'd1_100_000; r.hit_time[3] = 32'd1_800_000; records_to_send.push_back(r);
    r = base; r.last_sync = 32'hFFF0_0000; r.current_sync = 32'hFFF0_0000 + 32'd900_000;
    r.hit_time[0] = 32'hFFF0_0000 + 32'd100_000; r.hit_time[1] = 32'hFFF0_0000 + 32'd600_000;
    records_to_send.push_back(r);
    r = base; r.current_sync = 32'd100_000; records_to_send.push_back(r);
    r = base; r.current_sync = 32'd1_800_000; records_to_send.push_back(r);
    r = base; r.current_sync = 32'd1_970_000; records_to_send.push_back(r);
    r = base; r.current_sync = 32'd1_800_001; records_to_send.push_back(r);
    r = base; r.hit_time[1] = 32'd3_000_000; records_to_send.push_back(r);
    r = base; r.hit_time[0] = 32'd1_449_999; r.hit_time[1] = 32'd1_450_000;
    records_to_send.push_back(r);
    r = base; r.channel = 4'hF; r.sensor = 5'h1F; r.last_sync = '1; r.current_sync = '0;
    for (int i = 0; i < 4; i++) r.hit_time[i] = '1;
    r.sweep_count = 4'hF; records_to_send.push_back(r);
    r = base; r.hit_time[0] = '0; r.hit_time[1] = '0;
    r.hit_time[2] = 32'd1_100_000; r.hit_time[3] = 32'd1_600_000; records_to_send.push_back(r);
    r = base; r.frame_end = 1'b1; records_to_send.push_back(r);
    records_to_send.push_back(base);
    r = base; r.channel_ready = 1'b0; r.frame_end = 1'b1; records_to_send.push_back(r);
    records_to_send.push_back(base);
    r = base; r.last_sync = 32'd1; r.current_sync = '1;
    r.hit_time[0] = 32'd200_000; r.hit_time[1] = 32'd700_000; records_to_send.push_back(r);
    drain();

    queue_batch(110, 0);
    drain();
    queue_batch(80, 12);
    drain();

    set_limits(32'h0000_0000, 32'hFFFF_FFFF, 32'd900_000);
    send_idle_pct = 51;
    queue_batch(190, 8);
    drain();

    set_limits(32'hFFFF_FFFF, 32'h0000_0000, 32'd1);
    send_idle_pct = 0;
    stall_pct = 51;
    queue_batch(190, 8);
    drain();

    set_limits(32'd500_000, 32'd2_000_000, 32'hFFFF_FFFF);
    send_idle_pct = 14;
    stall_pct = 14;
    queue_batch(190, 8);
    drain();

    set_limits(shc_pkg::PERIOD_MIN_RST, shc_pkg::PERIOD_MAX_RST,
               shc_pkg::FALLBACK_PERIOD_RST);
    queue_batch(190, 3);
    drain();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
